// ----- rtl/slpscan_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep-state scanner package
// Word types, parse phases, byte constants and the name matcher that the
// scanner's step logic and top level share.
// ----------------------------------------------------------------------------
package slpscan_pkg;

   // Input word: one table body byte and the end-of-table flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   // Result word: found flag and the two sleep type values.
   typedef struct packed {
      logic       found;
      logic [7:0] sleep_type_a;
      logic [7:0] sleep_type_b;
   } rsp_word_type;

   // Parse phases. Code 7 is unused and is handled as searching.
   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_NAME   = 3'd1,
      PH_AFTER8 = 3'd2,
      PH_LEAD   = 3'd3,
      PH_SKIP   = 3'd4,
      PH_VAL_A  = 3'd5,
      PH_VAL_B  = 3'd6
   } phase_type;

   // Scanner state carried from byte to byte.
   typedef struct packed {
      phase_type  phase;
      logic [2:0] match_progress;
      logic [1:0] skip_count;
      logic [7:0] first_value;
      logic       already_reported;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      phase:            PH_SEARCH,
      match_progress:   3'd0,
      skip_count:       2'd0,
      first_value:      8'd0,
      already_reported: 1'b0
   };

   // Byte codes.
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_S          = 8'h53;
   localparam logic [7:0] CHAR_FIVE       = 8'h35;
   localparam logic [7:0] PACKAGE_OP      = 8'h12;
   localparam logic [7:0] NAME_OP         = 8'h08;
   localparam logic [7:0] BYTE_PREFIX     = 8'h0A;

   // Number of characters in the object name.
   localparam logic [2:0] NAME_LEN = 3'd4;

   // Character of "_S5_" at a given position.
   function automatic logic [7:0] name_char(input logic [1:0] pos);
      logic [7:0] ch;
      unique case (pos)
         2'd0:    ch = CHAR_UNDERSCORE;
         2'd1:    ch = CHAR_S;
         2'd2:    ch = CHAR_FIVE;
         default: ch = CHAR_UNDERSCORE;
      endcase
      return ch;
   endfunction

   // Advance the name match by one byte; a miss restarts on an underscore.
   function automatic logic [2:0] advance_match(input logic [2:0] progress,
                                                input logic [7:0] byte_val);
      logic [2:0] result;
      if (progress < NAME_LEN && byte_val == name_char(progress[1:0])) begin
         result = progress + 3'd1;
      end else if (byte_val == CHAR_UNDERSCORE) begin
         result = 3'd1;
      end else begin
         result = 3'd0;
      end
      return result;
   endfunction

endpackage

// ----- rtl/slpscan_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep-state scanner step logic
// Combinational next-state and result logic for one table body byte.
// ----------------------------------------------------------------------------
module slpscan_step
   import slpscan_pkg::*;
(
   input  scan_state_type cur_state,
   input  req_word_type   req_word,
   output scan_state_type next_state,
   output logic           emit,
   output rsp_word_type   result
);

   logic [7:0] data_b;

   assign data_b = req_word.data_byte;

   // Parse one byte, then close the table on its final byte.
   always_comb begin
      next_state = cur_state;
      emit       = 1'b0;
      result     = '0;

      if (!cur_state.already_reported) begin
         unique case (cur_state.phase)
            PH_NAME: begin
               if (data_b == PACKAGE_OP) begin
                  next_state.phase = PH_LEAD;
               end else if (data_b == NAME_OP) begin
                  next_state.phase = PH_AFTER8;
               end else begin
                  // Resume as if the search restarted one byte into the name.
                  next_state.match_progress = advance_match(3'd1, data_b);
                  next_state.phase          = PH_SEARCH;
               end
            end
            PH_AFTER8: begin
               if (data_b == PACKAGE_OP) begin
                  next_state.phase = PH_LEAD;
               end else begin
                  next_state.match_progress = advance_match(3'd0, data_b);
                  next_state.phase          = PH_SEARCH;
               end
            end
            PH_LEAD: begin
               next_state.skip_count = data_b[7:6];
               next_state.phase      = PH_SKIP;
            end
            PH_SKIP: begin
               // Extra length bytes, then the element count byte.
               if (cur_state.skip_count == 2'd0) begin
                  next_state.phase = PH_VAL_A;
               end else begin
                  next_state.skip_count = cur_state.skip_count - 2'd1;
               end
            end
            PH_VAL_A: begin
               if (cur_state.skip_count == 2'd0 && data_b == BYTE_PREFIX) begin
                  next_state.skip_count = 2'd1;
               end else begin
                  next_state.first_value = data_b;
                  next_state.skip_count  = 2'd0;
                  next_state.phase       = PH_VAL_B;
               end
            end
            PH_VAL_B: begin
               if (cur_state.skip_count == 2'd0 && data_b == BYTE_PREFIX) begin
                  next_state.skip_count = 2'd1;
               end else begin
                  emit                        = 1'b1;
                  result.found                = 1'b1;
                  result.sleep_type_a         = cur_state.first_value;
                  result.sleep_type_b         = data_b;
                  next_state.already_reported = 1'b1;
                  next_state.skip_count       = 2'd0;
                  next_state.phase            = PH_SEARCH;
               end
            end
            default: begin
               // Searching for the name.
               next_state.match_progress =
                  advance_match(cur_state.match_progress, data_b);
               if (next_state.match_progress == NAME_LEN) begin
                  next_state.match_progress = 3'd0;
                  next_state.phase          = PH_NAME;
               end else begin
                  next_state.phase = PH_SEARCH;
               end
            end
         endcase
      end

      // End of table: report not-found unless already reported, then restart.
      if (req_word.last_byte) begin
         if (!emit && !cur_state.already_reported) begin
            emit   = 1'b1;
            result = '0;
         end
         next_state = SCAN_RESET;
      end
   end

endmodule

// ----- rtl/aml_sleep_state_scanner_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep-state scanner top level
// Scans a table body byte stream for the "_S5_" package and reports the
// two sleep type values, or not-found when the table ends without it.
//
//   Channel  Direction  Handshake              Word
//   req      in         req_valid / req_ready  req_word_type (byte, last)
//   rsp      out        rsp_valid / rsp_ready  rsp_word_type (found, a, b)
//
// One byte is taken every cycle while req_ready is high; its result, if any,
// appears in the result register on the following cycle. The scan state
// register is updated by one pass of step logic per byte. req_ready is low
// only while a result is held and rsp_ready is low. Synchronous reset
// returns to searching with no result pending.
// ----------------------------------------------------------------------------
module aml_sleep_state_scanner_top
   import slpscan_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   scan_state_type state_ff;
   scan_state_type state_in;
   logic           rsp_valid_ff;
   rsp_word_type   rsp_word_ff;
   logic           emit;
   rsp_word_type   result;
   logic           req_accept;

   // A word is taken whenever the result register is free or being emptied.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   slpscan_step u_step (
      .cur_state  (state_ff),
      .req_word   (req_word),
      .next_state (state_in),
      .emit       (emit),
      .result     (result)
   );

   // Scan state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_RESET;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_word_ff <= result;
      end
   end

   // A new result only ever follows an accepted word.
   a_result_follows_word : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept))
      else $error("result appeared without an accepted word");

   // The final byte of a table always restores the search state.
   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_word.last_byte) |=>
         (state_ff.phase == PH_SEARCH && state_ff.match_progress == 3'd0 &&
          !state_ff.already_reported && state_ff.skip_count == 2'd0))
      else $error("scan state not restored after final byte");

   // A not-found result carries zero sleep types.
   a_not_found_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.found) |->
         (rsp_word_ff.sleep_type_a == 8'd0 && rsp_word_ff.sleep_type_b == 8'd0))
      else $error("not-found result with non-zero values");

   // Match progress is only kept while searching, and never reaches the full name.
   a_progress_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff.match_progress < NAME_LEN) &&
      (state_ff.phase == PH_SEARCH || state_ff.match_progress == 3'd0))
      else $error("match progress out of range");

endmodule

// ----- tb/aml_sleep_state_scanner_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sleep-state scanner testbench
// Streams directed and random table bodies into the scanner one word at a
// time. A behavioural copy of the scan predicts each report word, and every
// returned word is compared with the oldest prediction. Random tables run
// under four sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module aml_sleep_state_scanner_top_tb
   import slpscan_pkg::*;
();

   localparam int WATCHDOG_LIMIT         = 2000;
   localparam int RANDOM_BYTES_PER_PHASE = 170;
   localparam int DRAIN_CYCLES           = 5;

   // "_S5_" packed with the first character in the low byte.
   localparam logic [31:0] NAME_BYTES = {CHAR_UNDERSCORE, CHAR_FIVE, CHAR_S, CHAR_UNDERSCORE};

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   int idle_pct       = 0;
   int stall_pct      = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // Predicted scan state, kept in step with the accepted input words.
   phase_type  scan_phase   = PH_SEARCH;
   logic [2:0] name_matched = '0;
   logic [1:0] skip_left    = '0;
   logic [7:0] value_a      = '0;
   logic       reported     = 1'b0;

   rsp_word_type pending_reports[$];
   logic [7:0]   tbl_bytes[$];

   aml_sleep_state_scanner_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Name matcher: a miss restarts the match when the byte is an underscore.
   function automatic logic [2:0] match_step(input logic [2:0] matched, input logic [7:0] b);
      if (matched < NAME_LEN && b == NAME_BYTES[8 * matched[1:0] +: 8]) begin
         return matched + 3'd1;
      end
      return (b == CHAR_UNDERSCORE) ? 3'd1 : 3'd0;
   endfunction

   // Advance the predicted scan by one word and queue any report it causes.
   function automatic void predict_scan(input req_word_type w);
      rsp_word_type word;
      logic         produced;
      word     = '0;
      produced = 1'b0;
      if (!reported) begin
         case (scan_phase)
            PH_NAME: begin
               if (w.data_byte == PACKAGE_OP) begin
                  scan_phase = PH_LEAD;
               end else if (w.data_byte == NAME_OP) begin
                  scan_phase = PH_AFTER8;
               end else begin
                  // The name's final underscore may begin a new match.
                  name_matched = match_step(3'd1, w.data_byte);
                  scan_phase   = PH_SEARCH;
               end
            end
            PH_AFTER8: begin
               if (w.data_byte == PACKAGE_OP) begin
                  scan_phase = PH_LEAD;
               end else begin
                  name_matched = match_step(3'd0, w.data_byte);
                  scan_phase   = PH_SEARCH;
               end
            end
            PH_LEAD: begin
               skip_left  = w.data_byte[7:6];
               scan_phase = PH_SKIP;
            end
            PH_SKIP: begin
               if (skip_left == 2'd0) begin
                  scan_phase = PH_VAL_A;
               end else begin
                  skip_left = skip_left - 2'd1;
               end
            end
            PH_VAL_A: begin
               if (skip_left == 2'd0 && w.data_byte == BYTE_PREFIX) begin
                  skip_left = 2'd1;
               end else begin
                  value_a    = w.data_byte;
                  skip_left  = 2'd0;
                  scan_phase = PH_VAL_B;
               end
            end
            PH_VAL_B: begin
               if (skip_left == 2'd0 && w.data_byte == BYTE_PREFIX) begin
                  skip_left = 2'd1;
               end else begin
                  word.found        = 1'b1;
                  word.sleep_type_a = value_a;
                  word.sleep_type_b = w.data_byte;
                  produced          = 1'b1;
                  reported          = 1'b1;
                  skip_left         = 2'd0;
                  scan_phase        = PH_SEARCH;
               end
            end
            default: begin
               name_matched = match_step(name_matched, w.data_byte);
               if (name_matched == NAME_LEN) begin
                  name_matched = 3'd0;
                  scan_phase   = PH_NAME;
               end else begin
                  scan_phase = PH_SEARCH;
               end
            end
         endcase
      end
      if (produced) begin
         pending_reports.push_back(word);
      end
      // The final word reports not-found unless the package was already seen.
      if (w.last_byte) begin
         if (!reported) begin
            pending_reports.push_back('0);
         end
         scan_phase   = PH_SEARCH;
         name_matched = '0;
         skip_left    = '0;
         value_a      = '0;
         reported     = 1'b0;
      end
   endfunction

   // Random byte that favours the codes the scanner reacts to.
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      case ($urandom_range(9))
         0:       b = CHAR_UNDERSCORE;
         1:       b = CHAR_S;
         2:       b = CHAR_FIVE;
         3:       b = PACKAGE_OP;
         4:       b = NAME_OP;
         5:       b = BYTE_PREFIX;
         default: b = 8'($urandom_range(255));
      endcase
      return b;
   endfunction

   function automatic void push_name();
      for (int i = 0; i < 4; i++) begin
         tbl_bytes.push_back(NAME_BYTES[8 * i +: 8]);
      end
   endfunction

   // A package value, sometimes behind the byte prefix.
   function automatic void push_value();
      if ($urandom_range(2) == 0) begin
         tbl_bytes.push_back(BYTE_PREFIX);
      end
      tbl_bytes.push_back(($urandom_range(3) == 0) ? noise_byte() : 8'($urandom_range(255)));
   endfunction

   // Mostly well-formed packages with random content; the rest are truncated,
   // corrupted or pure noise.
   function automatic void build_random_table();
      int         shape;
      int         cut;
      logic [7:0] lead;
      shape = $urandom_range(99);
      if (shape < 10) begin
         repeat ($urandom_range(20, 1)) tbl_bytes.push_back(noise_byte());
         return;
      end
      repeat ($urandom_range(6)) tbl_bytes.push_back(noise_byte());
      if ($urandom_range(3) == 0) begin
         tbl_bytes.push_back(CHAR_UNDERSCORE);
         tbl_bytes.push_back(CHAR_S);
         if ($urandom_range(1) == 1) begin
            tbl_bytes.push_back(CHAR_FIVE);
         end
      end
      push_name();
      if ($urandom_range(1) == 1) begin
         tbl_bytes.push_back(NAME_OP);
      end
      tbl_bytes.push_back(PACKAGE_OP);
      lead = 8'($urandom_range(255));
      tbl_bytes.push_back(lead);
      repeat (lead[7:6]) tbl_bytes.push_back(8'($urandom_range(255)));
      tbl_bytes.push_back(8'($urandom_range(255)));
      push_value();
      push_value();
      repeat ($urandom_range(4)) tbl_bytes.push_back(noise_byte());
      if (shape < 25) begin
         tbl_bytes[$urandom_range(tbl_bytes.size() - 1)] = noise_byte();
      end else if (shape < 40) begin
         cut = $urandom_range(tbl_bytes.size(), 1);
         while (tbl_bytes.size() > cut) void'(tbl_bytes.pop_back());
      end
   endfunction

   // Offer one word at the falling edge, idling first at random, and wait
   // for it to be taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{data_byte: b, last_byte: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_scan(req_word);
   endtask

   task automatic send_table();
      foreach (tbl_bytes[i]) begin
         send_byte(tbl_bytes[i], i == tbl_bytes.size() - 1);
      end
      tbl_bytes.delete();
   endtask

   // Stop sending until every predicted report has been returned.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   // Name, name prefix, largest lead skip, and the package completed on the
   // final word with extreme values.
   task automatic test_full_package();
      push_name();
      tbl_bytes.push_back(NAME_OP);
      tbl_bytes.push_back(PACKAGE_OP);
      tbl_bytes.push_back(8'hC0);
      tbl_bytes.push_back(8'hFF);
      tbl_bytes.push_back(8'h00);
      tbl_bytes.push_back(8'h5A);
      tbl_bytes.push_back(8'h07);
      tbl_bytes.push_back(8'h00);
      tbl_bytes.push_back(8'hFF);
      send_table();
   endtask

   // A name followed by a second overlapping name, prefixed values (the
   // prefix byte itself as a value) and a trailing word after the report.
   task automatic test_name_fallback();
      push_name();
      tbl_bytes.push_back(CHAR_S);
      tbl_bytes.push_back(CHAR_FIVE);
      tbl_bytes.push_back(CHAR_UNDERSCORE);
      tbl_bytes.push_back(PACKAGE_OP);
      tbl_bytes.push_back(8'h3F);
      tbl_bytes.push_back(8'h02);
      tbl_bytes.push_back(BYTE_PREFIX);
      tbl_bytes.push_back(BYTE_PREFIX);
      tbl_bytes.push_back(8'h07);
      tbl_bytes.push_back(8'hAA);
      send_table();
   endtask

   // The name prefix without the package opcode, then the table ends.
   task automatic test_table_end();
      push_name();
      tbl_bytes.push_back(NAME_OP);
      tbl_bytes.push_back(8'h00);
      send_table();
   endtask

   task automatic test_random_tables(input int sender_idle, input int receiver_stall);
      int sent;
      sent      = 0;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      hold_until_drained();
      while (sent < RANDOM_BYTES_PER_PHASE) begin
         build_random_table();
         sent += tbl_bytes.size();
         send_table();
      end
   endtask

   // Receiver: drop ready at random at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Compare each accepted report word with the oldest prediction.
   always @(posedge clock) begin : check_reports
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected report word %0h", rsp_word);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_word.found !== want.found) begin
               $error("found: expected %0h, got %0h", want.found, rsp_word.found);
               mismatch_count++;
            end
            if (rsp_word.sleep_type_a !== want.sleep_type_a) begin
               $error("sleep_type_a: expected %0h, got %0h",
                      want.sleep_type_a, rsp_word.sleep_type_a);
               mismatch_count++;
            end
            if (rsp_word.sleep_type_b !== want.sleep_type_b) begin
               $error("sleep_type_b: expected %0h, got %0h",
                      want.sleep_type_b, rsp_word.sleep_type_b);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_full_package();
      test_name_fallback();
      test_table_end();
      test_random_tables(0, 0);
      test_random_tables(86, 0);
      test_random_tables(0, 86);
      test_random_tables(22, 22);
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/slpscan_pkg.sv
rtl/slpscan_step.sv
rtl/aml_sleep_state_scanner_top.sv
tb/aml_sleep_state_scanner_top_tb.sv
